// ===== hw/rtl/bm25_pkg.sv =====
`default_nettype none
package bm25_pkg;
  localparam int SCORE_FRAC_BITS_DEF = 16;
  localparam int QDEPTH = 4;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [1:0] REG_N = 2'd0;
  localparam logic [1:0] REG_AVDL = 2'd1;
  localparam logic [1:0] REG_K1 = 2'd2;
  localparam logic [1:0] REG_B = 2'd3;

  typedef struct packed {
    logic [16:0] la_arg;
    logic [16:0] lb_arg;
    logic [15:0] tf;
    logic [19:0] dl;
    logic        last;
  } bm25_work_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOGA, ST_LOGB, ST_IDF, ST_RATIO, ST_KQ, ST_DEN, ST_TFDIV,
    ST_PROD, ST_ACC, ST_OUT
  } bm25_state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bm25_document_scorer.sv =====
`default_nettype none
// BM25 document scorer. Feed one word per query term (df, tf, document length,
// last flag); the word with last_term set ends the document and yields one
// Q16.16 score word, clipped to 32 bits with saturated set on any clipping.
// A front stage clamps df and queues up to four words; the back sequencer
// handles one term at a time, and two log2 passes plus two restoring
// divisions (dl/avdl and the tf part, skipped when its denominator is zero)
// dominate its work. A finished score waits in the output register; only the
// next document's last term stalls on it. Registers (APB, byte address 4*i):
// collection_size, avg_doc_length, k1_gain, b_weight.
module bm25_document_scorer #(
  parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        doc_frequency,
  input  wire logic [15:0]        term_count,
  input  wire logic [19:0]        doc_len,
  input  wire logic               last_term,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      score,
  output logic                    saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import bm25_pkg::*;
  logic [15:0] n_reg;
  logic [27:0] avdl_reg;
  logic [9:0]  k1_reg;
  logic [8:0]  b_reg;
  logic        q_valid, q_pop;
  bm25_work_t  q_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg <= 16'd200;
      avdl_reg <= 28'd256;
      k1_reg <= 10'd307;
      b_reg <= 9'd192;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_N:    n_reg <= pwdata[15:0];
        REG_AVDL: avdl_reg <= pwdata[27:0];
        REG_K1:   k1_reg <= pwdata[9:0];
        REG_B:    b_reg <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_N:    prdata = {16'd0, n_reg};
      REG_AVDL: prdata = {4'd0, avdl_reg};
      REG_K1:   prdata = {22'd0, k1_reg};
      REG_B:    prdata = {23'd0, b_reg};
    endcase
  end

  bm25_front u_front (.clk, .rst, .in_valid, .in_ready, .doc_frequency,
    .term_count, .doc_len, .last_term, .n_reg, .q_valid, .q_pop, .q_data);

  bm25_back #(.SCORE_FRAC_BITS(SCORE_FRAC_BITS)) u_back (.clk, .rst, .q_valid,
    .q_pop, .q_data, .avdl_reg, .k1_reg, .b_reg, .out_valid, .out_ready,
    .score, .saturated);
endmodule
`default_nettype wire

// ===== hw/rtl/bm25_front.sv =====
`default_nettype none
// Clamp df to N, form the two log arguments and queue the word.
module bm25_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [15:0]            doc_frequency,
  input  wire logic [15:0]            term_count,
  input  wire logic [19:0]            doc_len,
  input  wire logic                   last_term,
  input  wire logic [15:0]            n_reg,
  output logic                        q_valid,
  input  wire logic                   q_pop,
  output bm25_pkg::bm25_work_t        q_data
);
  import bm25_pkg::*;
  localparam int AW = $clog2(QDEPTH);
  bm25_work_t mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic [15:0] d;
  bm25_work_t w;
  logic push;

  always_comb begin
    d = (doc_frequency > n_reg) ? n_reg : doc_frequency;
    w.la_arg = {(n_reg - d), 1'b1};
    w.lb_arg = {d, 1'b1};
    w.tf = term_count;
    w.dl = doc_len;
    w.last = last_term;
  end

  assign in_ready = (cnt != QDEPTH[AW:0]);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != '0);
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= w;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      cnt <= cnt + {{AW{1'b0}}, push} - {{AW{1'b0}}, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bm25_log2.sv =====
`default_nettype none
// Iterative log2 in Q24: leading one, then 24 squaring steps.
module bm25_log2 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [16:0] x,
  output logic             done,
  output logic [28:0]      result
);
  logic [4:0]  p, p_next;
  logic [31:0] m;
  logic [23:0] frac;
  logic [4:0]  step;
  logic        busy;
  logic [63:0] sq;
  logic [31:0] msq;

  always_comb begin
    p_next = '0;
    for (int i = 0; i < 17; i++) if (x[i]) p_next = 5'(i);
  end

  assign sq = {32'd0, m} * {32'd0, m};
  assign msq = sq[61:30];
  assign result = {p, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        p <= p_next;
        m <= 32'({15'd0, x} << (5'd30 - p_next));
        frac <= '0;
      end else if (busy) begin
        frac <= {frac[22:0], msq[31]};
        m <= msq[31] ? {1'b0, msq[31:1]} : msq;
        step <= step + 1'b1;
        if (step == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bm25_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module bm25_div #(
  parameter int NW = 64,
  parameter int DW = 56
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] n;
  logic [DW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   t;

  assign t = {rem[DW-1:0], n[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        n <= num;
        dv <= den;
        cnt <= '0;
      end else if (busy) begin
        n <= {n[NW-2:0], 1'b0};
        if (t >= {1'b0, dv}) begin
          rem <= t - {1'b0, dv};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= t;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bm25_back.sv =====
`default_nettype none
// Sequencer: log, idf, ratio, tf part, accumulate, emit.
module bm25_back #(
  parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire bm25_pkg::bm25_work_t q_data,
  input  wire logic [27:0]          avdl_reg,
  input  wire logic [9:0]           k1_reg,
  input  wire logic [8:0]           b_reg,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        score,
  output logic                      saturated
);
  import bm25_pkg::*;
  localparam int SH = 40 - SCORE_FRAC_BITS;
  localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_MIN = {1'b1, 39'd0};

  bm25_state_t state, state_next;
  bm25_work_t  wk;
  logic [28:0] la;
  logic        neg;
  logic [28:0] lmag;
  logic [35:0] idf;
  logic [47:0] ratio;
  logic [47:0] kq;
  logic [55:0] den;
  logic [63:0] tfq;
  logic [63:0] prod;
  logic signed [39:0] acc;
  logic        ovf;

  logic        lg_start, lg_done;
  logic [16:0] lg_x;
  logic [28:0] lg_res;
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_quo;
  logic [55:0] dv_den;
  logic [58:0] lmul;
  logic [8:0]  bc;
  logic [63:0] cm;
  logic signed [41:0] sum;
  logic        out_hold;
  logic        acc_go;

  bm25_log2 u_log (.clk, .rst, .start(lg_start), .x(lg_x), .done(lg_done),
    .result(lg_res));
  bm25_div #(.NW(64), .DW(56)) u_div (.clk, .rst, .start(dv_start),
    .num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo));

  assign bc = (b_reg > 9'd256) ? 9'd256 : b_reg;
  assign lmul = {30'd0, lmag} * {29'd0, LN2_Q30};
  assign cm = (prod + (64'd1 << (SH - 1))) >> SH;
  assign sum = 42'(acc) + (neg ? -$signed({2'b00, cm[39:0]}) : $signed({2'b00, cm[39:0]}));
  assign den = {46'd0, k1_reg} * {8'd0, kq} + {16'd0, wk.tf, 24'd0};
  // hold the last term until the previous score word has left
  assign acc_go = !(wk.last && out_hold && !out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = ST_LOGA;
      ST_LOGA:  if (lg_done) state_next = ST_LOGB;
      ST_LOGB:  if (lg_done) state_next = ST_IDF;
      ST_IDF:   state_next = ST_RATIO;
      ST_RATIO: if (dv_done) state_next = ST_KQ;
      ST_KQ:    state_next = ST_DEN;
      ST_DEN:   state_next = (den == '0) ? ST_PROD : ST_TFDIV;
      ST_TFDIV: if (dv_done) state_next = ST_PROD;
      ST_PROD:  state_next = ST_ACC;
      ST_ACC:   if (acc_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    lg_start = 1'b0;
    lg_x = wk.la_arg;
    dv_start = 1'b0;
    dv_num = {20'd0, q_data.dl, 24'd0};
    dv_den = {28'd0, (avdl_reg == '0) ? 28'd1 : avdl_reg};
    q_pop = 1'b0;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        lg_start = 1'b1;
        lg_x = q_data.la_arg;
      end
      ST_LOGA: if (lg_done) begin
        lg_start = 1'b1;
        lg_x = wk.lb_arg;
      end
      ST_IDF: begin
        dv_start = 1'b1;
        dv_num = {20'd0, wk.dl, 24'd0};
      end
      ST_DEN: begin
        dv_start = (den != '0);
        dv_num = 64'({10'd0, 11'({1'b0, k1_reg} + 11'd256)} * {48'd0, wk.tf}) << 32;
        dv_den = den;
      end
      default: ;
    endcase
  end

  assign out_valid = out_hold;

  always_ff @(posedge clk) begin
    state <= rst ? ST_IDLE : state_next;
    if (state == ST_IDLE && q_valid) wk <= q_data;
    if (state == ST_LOGA && lg_done) la <= lg_res;
    if (state == ST_LOGB && lg_done) begin
      neg <= la < lg_res;
      lmag <= (la < lg_res) ? lg_res - la : la - lg_res;
    end
    if (state == ST_IDF) idf <= 36'((lmul + (59'd1 << 29)) >> 30);
    if (state == ST_RATIO && dv_done) ratio <= dv_quo[47:0];
    if (state == ST_KQ)
      kq <= 48'((({48'd0, 9'd256 - bc} << 16) + {48'd0, bc} * {9'd0, ratio}) >> 8);
    if (state == ST_DEN) tfq <= '0;
    if (state == ST_TFDIV && dv_done) tfq <= dv_quo;
    if (state == ST_PROD) prod <= {28'd0, idf} * {32'd0, tfq[31:0]};
    if (rst) begin
      acc <= '0;
      ovf <= 1'b0;
      out_hold <= 1'b0;
    end else begin
      if (state == ST_ACC && acc_go && wk.last) out_hold <= 1'b1;
      else if (out_ready) out_hold <= 1'b0;
      if (state == ST_ACC && acc_go) begin
        logic signed [39:0] s;
        logic o;
        s = sum[39:0];
        o = ovf;
        if (sum > 42'(ACC_MAX)) begin
          s = ACC_MAX;
          o = 1'b1;
        end else if (sum < 42'(ACC_MIN)) begin
          s = ACC_MIN;
          o = 1'b1;
        end
        if (wk.last) begin
          if (s > 40'sh007FFFFFFF) begin
            score <= 32'h7FFFFFFF;
            saturated <= 1'b1;
          end else if (s < -40'sh0080000000) begin
            score <= 32'h80000000;
            saturated <= 1'b1;
          end else begin
            score <= s[31:0];
            saturated <= o;
          end
          acc <= '0;
          ovf <= 1'b0;
        end else begin
          acc <= s;
          ovf <= o;
        end
      end
    end
  end
endmodule
`default_nettype wire
